// ===== src/rect_window_line_clipper_top_assert.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the rectangular window line clipper
// Shared property forms used by the checker module.
// ------------------------------------------------------------------------
`ifndef RECT_WINDOW_LINE_CLIPPER_TOP_ASSERT_SVH
`define RECT_WINDOW_LINE_CLIPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RWLC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rwlc assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RWLC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rwlc assertion failed");

`endif

// ===== src/rwlc_pkg.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rwlc_pkg
// Widths, codes and control structures shared by the line clipper files.
// ------------------------------------------------------------------------
package rwlc_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned DIFF_W      = COORD_WIDTH + 1;
  localparam int unsigned MAG_W       = COORD_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * MAG_W;
  localparam int unsigned REM_W       = MAG_W + 1;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned CNT_W       = $clog2(PROD_W + 1);
  localparam int unsigned ROUND_W     = 3;
  localparam int unsigned CFG_IDX_W   = 4;

  localparam logic [ROUND_W-1:0] CLIP_ROUNDS = ROUND_W'(4);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [3:0]                    ocode_t;

  localparam ocode_t OC_LEFT   = 4'b0001;
  localparam ocode_t OC_RIGHT  = 4'b0010;
  localparam ocode_t OC_BOTTOM = 4'b0100;
  localparam ocode_t OC_TOP    = 4'b1000;

  localparam coord_t X_MIN_RST = coord_t'(200);
  localparam coord_t X_MAX_RST = coord_t'(800);
  localparam coord_t Y_MIN_RST = coord_t'(200);
  localparam coord_t Y_MAX_RST = coord_t'(800);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 4'd0,
    REG_X_MAX = 4'd1,
    REG_Y_MIN = 4'd2,
    REG_Y_MAX = 4'd3
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic setup;
    logic mul;
    logic div_start;
    logic update;
    logic out_load;
    logic out_acc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial_acc;
    logic trivial_rej;
    logic div_busy;
  } sts_t;

endpackage

// ===== src/rwlc_div.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rwlc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
module rwlc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rwlc_pkg::PROD_W-1:0]   dividend_i,
  input  logic [rwlc_pkg::MAG_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [rwlc_pkg::PROD_W-1:0]   quotient_o
);

  logic [rwlc_pkg::PROD_W-1:0] quo_q;
  logic [rwlc_pkg::MAG_W-1:0]  rem_q;
  logic [rwlc_pkg::CNT_W-1:0]  cnt_q;
  logic                        busy_q;
  logic [rwlc_pkg::REM_W-1:0]  rem_sh;
  logic [rwlc_pkg::REM_W-1:0]  rem_sub;
  logic                        ge;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign rem_sh  = {rem_q, quo_q[rwlc_pkg::PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= rwlc_pkg::CNT_W'(rwlc_pkg::PROD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - rwlc_pkg::CNT_W'(1);
      if (cnt_q == rwlc_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[rwlc_pkg::PROD_W-2:0], ge};
      rem_q <= ge ? rem_sub[rwlc_pkg::MAG_W-1:0] : rem_sh[rwlc_pkg::MAG_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/rwlc_dpath.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rwlc_dpath
// Window registers, endpoint registers, outcodes, multiplier, divider and
// the result register of the line clipper.
// ------------------------------------------------------------------------
module rwlc_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [rwlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  rwlc_pkg::coord_t                cfg_data_i,
  input  rwlc_pkg::coord_t                start_x_i,
  input  rwlc_pkg::coord_t                start_y_i,
  input  rwlc_pkg::coord_t                end_x_i,
  input  rwlc_pkg::coord_t                end_y_i,
  input  rwlc_pkg::cmd_t                  cmd_i,
  output rwlc_pkg::sts_t                  sts_o,
  output logic                            accepted_o,
  output rwlc_pkg::coord_t                clip_start_x_o,
  output rwlc_pkg::coord_t                clip_start_y_o,
  output rwlc_pkg::coord_t                clip_end_x_o,
  output rwlc_pkg::coord_t                clip_end_y_o
);

  localparam int unsigned CW = rwlc_pkg::COORD_WIDTH;

  rwlc_pkg::coord_t x_min_q, x_max_q, y_min_q, y_max_q;
  rwlc_pkg::coord_t x1_q, y1_q, x2_q, y2_q;
  rwlc_pkg::ocode_t c1, c2, oc;

  logic                        sel_first, sel_vert;
  rwlc_pkg::coord_t            edge_val, base_val;
  rwlc_pkg::diff_t             dx, dy, a_val, b_val, d_val;

  logic [rwlc_pkg::MAG_W-1:0]  ma_q, mb_q, md_q;
  logic                        neg_q, dzero_q, first_q, vert_q;
  rwlc_pkg::coord_t            base_q, edge_q;
  logic [rwlc_pkg::PROD_W-1:0] prod_q;
  logic [rwlc_pkg::PROD_W-1:0] quotient;
  logic                        div_busy;

  logic [rwlc_pkg::PROD_W-1:0] qv;
  rwlc_pkg::sum_t              q_ext, base_ext, sum;
  logic [rwlc_pkg::SUM_W-CW:0] sum_hi;
  rwlc_pkg::coord_t            interp_val, nx, ny;

  logic                        acc_q;
  rwlc_pkg::coord_t            ox1_q, oy1_q, ox2_q, oy2_q;

  function automatic rwlc_pkg::ocode_t outcode(
    input rwlc_pkg::coord_t x, input rwlc_pkg::coord_t y,
    input rwlc_pkg::coord_t xmin, input rwlc_pkg::coord_t xmax,
    input rwlc_pkg::coord_t ymin, input rwlc_pkg::coord_t ymax
  );
    rwlc_pkg::ocode_t c;
    c = '0;
    if (x < xmin) c = c | rwlc_pkg::OC_LEFT;
    if (x > xmax) c = c | rwlc_pkg::OC_RIGHT;
    if (y < ymin) c = c | rwlc_pkg::OC_BOTTOM;
    if (y > ymax) c = c | rwlc_pkg::OC_TOP;
    return c;
  endfunction

  function automatic rwlc_pkg::diff_t sx(input rwlc_pkg::coord_t v);
    return {v[CW-1], v};
  endfunction

  function automatic logic [rwlc_pkg::MAG_W-1:0] mag(input rwlc_pkg::diff_t v);
    rwlc_pkg::diff_t n;
    n = -v;
    return v[rwlc_pkg::DIFF_W-1] ? n : v;
  endfunction

  // Window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= rwlc_pkg::X_MIN_RST;
      x_max_q <= rwlc_pkg::X_MAX_RST;
      y_min_q <= rwlc_pkg::Y_MIN_RST;
      y_max_q <= rwlc_pkg::Y_MAX_RST;
    end else if (cfg_valid_i) begin
      case (rwlc_pkg::cfg_reg_e'(cfg_index_i))
        rwlc_pkg::REG_X_MIN: x_min_q <= cfg_data_i;
        rwlc_pkg::REG_X_MAX: x_max_q <= cfg_data_i;
        rwlc_pkg::REG_Y_MIN: y_min_q <= cfg_data_i;
        rwlc_pkg::REG_Y_MAX: y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign c1 = outcode(x1_q, y1_q, x_min_q, x_max_q, y_min_q, y_max_q);
  assign c2 = outcode(x2_q, y2_q, x_min_q, x_max_q, y_min_q, y_max_q);

  assign sts_o.trivial_acc = (c1 | c2) == '0;
  assign sts_o.trivial_rej = (c1 & c2) != '0;
  assign sts_o.div_busy    = div_busy;

  // Edge choice and interpolation operands for one round.
  always_comb begin
    sel_first = c1 != '0;
    oc        = sel_first ? c1 : c2;
    sel_vert  = (oc & (rwlc_pkg::OC_TOP | rwlc_pkg::OC_BOTTOM)) != '0;
    if ((oc & rwlc_pkg::OC_TOP) != '0) begin
      edge_val = y_max_q;
    end else if ((oc & rwlc_pkg::OC_BOTTOM) != '0) begin
      edge_val = y_min_q;
    end else if ((oc & rwlc_pkg::OC_RIGHT) != '0) begin
      edge_val = x_max_q;
    end else begin
      edge_val = x_min_q;
    end
    dx = sx(x2_q) - sx(x1_q);
    dy = sx(y2_q) - sx(y1_q);
    if (sel_vert) begin
      a_val    = dx;
      b_val    = sx(edge_val) - sx(y1_q);
      d_val    = dy;
      base_val = x1_q;
    end else begin
      a_val    = dy;
      b_val    = sx(edge_val) - sx(x1_q);
      d_val    = dx;
      base_val = y1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x1_q <= start_x_i;
      y1_q <= start_y_i;
      x2_q <= end_x_i;
      y2_q <= end_y_i;
    end else if (cmd_i.update) begin
      if (first_q) begin
        x1_q <= nx;
        y1_q <= ny;
      end else begin
        x2_q <= nx;
        y2_q <= ny;
      end
    end
    if (cmd_i.setup) begin
      ma_q    <= mag(a_val);
      mb_q    <= mag(b_val);
      md_q    <= mag(d_val);
      neg_q   <= a_val[rwlc_pkg::DIFF_W-1] ^ b_val[rwlc_pkg::DIFF_W-1]
                 ^ d_val[rwlc_pkg::DIFF_W-1];
      dzero_q <= d_val == '0;
      base_q  <= base_val;
      edge_q  <= edge_val;
      first_q <= sel_first;
      vert_q  <= sel_vert;
    end
    if (cmd_i.mul) begin
      prod_q <= rwlc_pkg::PROD_W'(ma_q) * rwlc_pkg::PROD_W'(mb_q);
    end
  end

  rwlc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (md_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // The quotient magnitude stays below 2^(2*MAG_W), within the range of the signed sum.
  always_comb begin
    qv       = dzero_q ? '0 : quotient;
    q_ext    = {2'b00, qv};
    base_ext = {{(rwlc_pkg::SUM_W-CW){base_q[CW-1]}}, base_q};
    sum      = neg_q ? base_ext - q_ext : base_ext + q_ext;
    sum_hi   = sum[rwlc_pkg::SUM_W-1:CW-1];
    if ((sum_hi == '0) || (sum_hi == '1)) begin
      interp_val = sum[CW-1:0];
    end else if (sum[rwlc_pkg::SUM_W-1]) begin
      interp_val = {1'b1, {(CW-1){1'b0}}};
    end else begin
      interp_val = {1'b0, {(CW-1){1'b1}}};
    end
    nx = vert_q ? interp_val : edge_q;
    ny = vert_q ? edge_q : interp_val;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      acc_q <= cmd_i.out_acc;
      ox1_q <= cmd_i.out_acc ? x1_q : '0;
      oy1_q <= cmd_i.out_acc ? y1_q : '0;
      ox2_q <= cmd_i.out_acc ? x2_q : '0;
      oy2_q <= cmd_i.out_acc ? y2_q : '0;
    end
  end

  assign accepted_o     = acc_q;
  assign clip_start_x_o = ox1_q;
  assign clip_start_y_o = oy1_q;
  assign clip_end_x_o   = ox2_q;
  assign clip_end_y_o   = oy2_q;

endmodule

// ===== src/rwlc_ctrl.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rwlc_ctrl
// Sequencer for the clipping rounds and the output handshake.
// ------------------------------------------------------------------------
module rwlc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rwlc_pkg::sts_t sts_i,
  output rwlc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV_START,
    S_DIV,
    S_FINISH
  } state_e;

  state_e                        state_q;
  logic [rwlc_pkg::ROUND_W-1:0]  round_q;
  logic                          acc_q;
  logic                          out_valid_q;
  logic                          reject;

  assign reject = sts_i.trivial_rej || (round_q == rwlc_pkg::CLIP_ROUNDS);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.setup     = (state_q == S_EVAL) && !sts_i.trivial_acc && !reject;
    cmd_o.mul       = state_q == S_MUL;
    cmd_o.div_start = state_q == S_DIV_START;
    cmd_o.update    = (state_q == S_DIV) && !sts_i.div_busy;
    cmd_o.out_load  = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
    cmd_o.out_acc   = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            round_q <= '0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sts_i.trivial_acc) begin
            acc_q   <= 1'b1;
            state_q <= S_FINISH;
          end else if (reject) begin
            acc_q   <= 1'b0;
            state_q <= S_FINISH;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL:       state_q <= S_DIV_START;
        S_DIV_START: state_q <= S_DIV;
        S_DIV: begin
          if (!sts_i.div_busy) begin
            round_q <= round_q + rwlc_pkg::ROUND_W'(1);
            state_q <= S_EVAL;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/rect_window_line_clipper_top.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rect_window_line_clipper_top
// Clips one line segment against a rectangular window (outcode method).
// ------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o    start_x/y_i, end_x/y_i
//   out      out        out_valid_o / out_ready_i  accepted_o, clip_*_o
//
// An input transaction takes R clipping rounds, where R ranges from 0 to 4.
// Each round is dominated by the 34-step serial divider in the datapath.
// Reset is asynchronous and active low; the window returns to 200..800.
// A result that is not taken waits in the output register while the next
// transaction is already being accepted; a new result waits for that register.
//
// The controller steps through the rounds: it evaluates the outcodes,
// registers the interpolation operands, multiplies, divides and writes the
// moved endpoint back. The datapath holds the coordinate arithmetic and storage.
// Configuration writes are always accepted; an index beyond the four window
// registers is ignored.
// ------------------------------------------------------------------------
module rect_window_line_clipper_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rwlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rwlc_pkg::COORD_WIDTH-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [rwlc_pkg::COORD_WIDTH-1:0] start_x_i,
  input  logic signed [rwlc_pkg::COORD_WIDTH-1:0] start_y_i,
  input  logic signed [rwlc_pkg::COORD_WIDTH-1:0] end_x_i,
  input  logic signed [rwlc_pkg::COORD_WIDTH-1:0] end_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            accepted_o,
  output logic signed [rwlc_pkg::COORD_WIDTH-1:0] clip_start_x_o,
  output logic signed [rwlc_pkg::COORD_WIDTH-1:0] clip_start_y_o,
  output logic signed [rwlc_pkg::COORD_WIDTH-1:0] clip_end_x_o,
  output logic signed [rwlc_pkg::COORD_WIDTH-1:0] clip_end_y_o
);

  rwlc_pkg::cmd_t cmd;
  rwlc_pkg::sts_t sts;

  // The window may be rewritten at any time the block is idle, so the port
  // never stalls a configuration transaction.
  assign cfg_ready_o = 1'b1;

  rwlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rwlc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (rwlc_pkg::coord_t'(cfg_data_i)),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .accepted_o     (accepted_o),
    .clip_start_x_o (clip_start_x_o),
    .clip_start_y_o (clip_start_y_o),
    .clip_end_x_o   (clip_end_x_o),
    .clip_end_y_o   (clip_end_y_o)
  );

endmodule

// ===== src/rwlc_checker.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rwlc_checker
// Port-level checks on the line clipper, attached to the top level.
// ------------------------------------------------------------------------
`include "rect_window_line_clipper_top_assert.svh"

module rwlc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            accepted_o,
  input logic [rwlc_pkg::COORD_WIDTH-1:0] clip_start_x_o,
  input logic [rwlc_pkg::COORD_WIDTH-1:0] clip_start_y_o,
  input logic [rwlc_pkg::COORD_WIDTH-1:0] clip_end_x_o,
  input logic [rwlc_pkg::COORD_WIDTH-1:0] clip_end_y_o
);

  logic                                 out_stall;
  logic [4*rwlc_pkg::COORD_WIDTH:0]     payload;
  logic                                 coords_zero;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign payload     = {accepted_o, clip_start_x_o, clip_start_y_o, clip_end_x_o,
                        clip_end_y_o};
  assign coords_zero = payload[4*rwlc_pkg::COORD_WIDTH-1:0] == '0;

  // A stalled result keeps its payload.
  `RWLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(payload))

  // A rejected segment reports all coordinates as zero.
  `RWLC_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, out_valid_o && !accepted_o, coords_zero)

  // The block works on one segment at a time.
  `RWLC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A new result is issued only as the block returns to idle.
  `RWLC_ASSERT_IMP(a_result_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)

endmodule

bind rect_window_line_clipper_top rwlc_checker u_rwlc_checker (.*);
